### rtl/rad_pkg.sv
// Shared types, constants and control store for the run-length animation decoder.
package rad_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // span pointer: covers any start index, the store and one span beyond it
  localparam int POS_W       = $clog2(STORE_DEPTH + 4096 + 512);
  localparam int UPC_W       = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_RD_POS,
    A_LATCH_HDR,
    A_ADVANCE,
    A_VIDX,
    A_MUL,
    A_ADD,
    A_ERR,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE_STAY,
    C_NO_TRACK,
    C_POS_OOR,
    C_TOTAL_ZERO,
    C_IN_SPAN,
    C_OUT_BUSY
  } cond_t;

  localparam logic [UPC_W-1:0] U_WAIT     = 4'd0;
  localparam logic [UPC_W-1:0] U_TRACK    = 4'd1;
  localparam logic [UPC_W-1:0] U_HDR_RD   = 4'd2;
  localparam logic [UPC_W-1:0] U_HDR_CHK  = 4'd3;
  localparam logic [UPC_W-1:0] U_SPAN_CHK = 4'd4;
  localparam logic [UPC_W-1:0] U_ADVANCE  = 4'd5;
  localparam logic [UPC_W-1:0] U_VIDX     = 4'd6;
  localparam logic [UPC_W-1:0] U_VAL_RD   = 4'd7;
  localparam logic [UPC_W-1:0] U_MUL      = 4'd8;
  localparam logic [UPC_W-1:0] U_ADD      = 4'd9;
  localparam logic [UPC_W-1:0] U_ERR      = 4'd10;
  localparam logic [UPC_W-1:0] U_EMIT     = 4'd11;
  localparam logic [UPC_W-1:0] U_RETURN   = 4'd12;

  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [UPC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic no_track;
    logic pos_oor;
    logic total_zero;
    logic in_span;
    logic out_busy;
  } flags_t;

  // control store: action, jump condition, jump target; else fall through
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      U_WAIT:     w = '{A_ACCEPT,    C_IDLE_STAY,  U_WAIT};
      U_TRACK:    w = '{A_NONE,      C_NO_TRACK,   U_EMIT};
      U_HDR_RD:   w = '{A_RD_POS,    C_POS_OOR,    U_ERR};
      U_HDR_CHK:  w = '{A_LATCH_HDR, C_TOTAL_ZERO, U_ERR};
      U_SPAN_CHK: w = '{A_NONE,      C_IN_SPAN,    U_VIDX};
      U_ADVANCE:  w = '{A_ADVANCE,   C_ALWAYS,     U_HDR_RD};
      U_VIDX:     w = '{A_VIDX,      C_NEVER,      U_WAIT};
      U_VAL_RD:   w = '{A_RD_POS,    C_POS_OOR,    U_ERR};
      U_MUL:      w = '{A_MUL,       C_NEVER,      U_WAIT};
      U_ADD:      w = '{A_ADD,       C_ALWAYS,     U_EMIT};
      U_ERR:      w = '{A_ERR,       C_NEVER,      U_WAIT};
      U_EMIT:     w = '{A_EMIT,      C_OUT_BUSY,   U_EMIT};
      U_RETURN:   w = '{A_NONE,      C_ALWAYS,     U_WAIT};
      default:    w = '{A_NONE,      C_ALWAYS,     U_WAIT};
    endcase
    return w;
  endfunction

endpackage

### rtl/rad_if.sv
// Valid/ready channel interfaces for query/load items and decoded results.
interface rad_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [11:0]         entry_index;
  logic [15:0]         entry_word;
  logic                has_track;
  logic [11:0]         start_index;
  logic [15:0]         frame_number;
  logic signed [31:0]  default_value;
  logic signed [31:0]  scale_factor;

  modport source (output valid, opcode, entry_index, entry_word, has_track, start_index,
                  frame_number, default_value, scale_factor, input ready);
  modport sink   (input valid, opcode, entry_index, entry_word, has_track, start_index,
                  frame_number, default_value, scale_factor, output ready);
endinterface

interface rad_out_if;
  logic                valid;
  logic                ready;
  logic signed [47:0]  channel_value;
  logic                decode_error;

  modport source (output valid, channel_value, decode_error, input ready);
  modport sink   (input valid, channel_value, decode_error, output ready);
endinterface

### rtl/rle_anim_channel_decode_core.sv
// Top level of the run-length animation channel decoder.
// Holds a 4096-entry store of 16-bit run-length animation words and decodes
// one channel value per query. A load item (opcode 0) writes one entry,
// gives no result and leaves the block ready for the next item. A query
// (opcode 1) walks span headers from start_index, one store read per step,
// until the frame falls inside a span, then reads the value, multiplies it
// by scale_factor and adds default_value (Q32.16, saturated). A query
// without a track gives default_value without a walk. The pace of a query
// is set by the single store port and the sequencer program, which spends
// four steps per header and one return step after each result. While an
// earlier result still waits on out_, the emit step holds and the input
// stays closed. A zero total or any read beyond the store gives
// decode_error with the default value. The store has no reset: reads of
// unwritten entries give undefined data. The next item is taken while a
// result still waits on out_.
module rle_anim_channel_decode_core (
  input  logic      clk,
  input  logic      rst_n,
  rad_in_if.sink    in_chan,
  rad_out_if.source out_chan
);

  rad_pkg::uword_t              uword;
  rad_pkg::flags_t              flags;
  logic [rad_pkg::UPC_W-1:0]    upc;

  // program counter and control store
  rad_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uword (uword),
    .upc   (upc)
  );

  // store, walk registers and arithmetic, driven by the control word
  rad_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .uword    (uword),
    .flags    (flags),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

`ifndef NO_ASSERTIONS
  // a load transfer never stops the sequencer from waiting
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.opcode == rad_pkg::OP_LOAD))
    |=> in_chan.ready)
    else $error("load transfer left the wait step");

  // a query transfer starts a walk, so input is closed next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.opcode == rad_pkg::OP_QUERY))
    |=> !in_chan.ready)
    else $error("query transfer did not start the walk");

  // results appear only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(upc == rad_pkg::U_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

### rtl/rad_useq.sv
// Microsequencer: step counter, control store lookup and conditional jumps.
module rad_useq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rad_pkg::flags_t              flags,
  output rad_pkg::uword_t              uword,
  output logic [rad_pkg::UPC_W-1:0]    upc
);

  logic [rad_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic                      take;

  assign uword = rad_pkg::ucode_rom(upc_r);
  assign upc   = upc_r;

  always_comb begin
    case (uword.cond)
      rad_pkg::C_NEVER:      take = 1'b0;
      rad_pkg::C_ALWAYS:     take = 1'b1;
      rad_pkg::C_IDLE_STAY:  take = !flags.go;
      rad_pkg::C_NO_TRACK:   take = flags.no_track;
      rad_pkg::C_POS_OOR:    take = flags.pos_oor;
      rad_pkg::C_TOTAL_ZERO: take = flags.total_zero;
      rad_pkg::C_IN_SPAN:    take = flags.in_span;
      rad_pkg::C_OUT_BUSY:   take = flags.out_busy;
      default:               take = 1'b1;
    endcase
    upc_nxt = take ? uword.target : upc_r + rad_pkg::UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rad_pkg::U_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/rad_dpath.sv
// Datapath: entry store, span walk registers, multiply-add and output register.
module rad_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  rad_pkg::uword_t  uword,
  output rad_pkg::flags_t  flags,
  rad_in_if.sink           in_chan,
  rad_out_if.source        out_chan
);

  logic [15:0]                 mem [rad_pkg::STORE_DEPTH];
  logic [15:0]                 rdata_r;
  logic                        has_track_r;
  logic [rad_pkg::POS_W-1:0]   pos_r;
  logic [15:0]                 k_r;
  logic [7:0]                  valid_r, total_r;
  logic signed [31:0]          default_r, scale_r;
  logic signed [47:0]          prod_r, result_r;
  logic                        err_r;
  logic                        out_valid_r;
  logic signed [47:0]          out_value_r;
  logic                        out_err_r;

  logic                        accept, is_query, out_busy, emit;
  logic [rad_pkg::POS_W-1:0]   widx;
  logic signed [48:0]          sum;
  logic signed [47:0]          sat_sum;

  assign in_chan.ready = (uword.act == rad_pkg::A_ACCEPT);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_query      = (in_chan.opcode == rad_pkg::OP_QUERY);
  assign widx          = rad_pkg::POS_W'(in_chan.entry_index);
  assign out_busy      = out_valid_r && !out_chan.ready;
  assign emit          = (uword.act == rad_pkg::A_EMIT) && !out_busy;

  assign flags.go         = accept && is_query;
  assign flags.no_track   = !has_track_r;
  assign flags.pos_oor    = (pos_r >= rad_pkg::POS_W'(rad_pkg::STORE_DEPTH));
  assign flags.total_zero = (rdata_r[15:8] == 8'd0);
  assign flags.in_span    = ({8'd0, total_r} > k_r);
  assign flags.out_busy   = out_busy;

  // 49-bit sum, then clamp to the 48-bit range
  assign sum = {{17{default_r[31]}}, default_r} + {prod_r[47], prod_r};
  always_comb begin
    if (sum[48] != sum[47]) begin
      sat_sum = sum[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      sat_sum = sum[47:0];
    end
  end

  // store: written on a load transfer, read by header and value steps
  always_ff @(posedge clk) begin
    if (accept && !is_query && (widx < rad_pkg::POS_W'(rad_pkg::STORE_DEPTH))) begin
      mem[widx[rad_pkg::ADDR_W-1:0]] <= in_chan.entry_word;
    end
    if ((uword.act == rad_pkg::A_RD_POS) && !flags.pos_oor) begin
      rdata_r <= mem[pos_r[rad_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    case (uword.act)
      rad_pkg::A_ACCEPT: begin
        if (accept && is_query) begin
          has_track_r <= in_chan.has_track;
          pos_r       <= rad_pkg::POS_W'(in_chan.start_index);
          k_r         <= in_chan.frame_number;
          default_r   <= in_chan.default_value;
          scale_r     <= in_chan.scale_factor;
          result_r    <= 48'(in_chan.default_value);
          err_r       <= 1'b0;
        end
      end
      rad_pkg::A_LATCH_HDR: begin
        valid_r <= rdata_r[7:0];
        total_r <= rdata_r[15:8];
      end
      rad_pkg::A_ADVANCE: begin
        k_r   <= k_r - {8'd0, total_r};
        pos_r <= pos_r + rad_pkg::POS_W'(valid_r) + rad_pkg::POS_W'(1);
      end
      rad_pkg::A_VIDX: begin
        if ({8'd0, valid_r} > k_r) begin
          pos_r <= pos_r + rad_pkg::POS_W'(k_r[7:0]) + rad_pkg::POS_W'(1);
        end else begin
          pos_r <= pos_r + rad_pkg::POS_W'(valid_r);
        end
      end
      rad_pkg::A_MUL: prod_r <= $signed(rdata_r) * scale_r;
      rad_pkg::A_ADD: result_r <= sat_sum;
      rad_pkg::A_ERR: begin
        result_r <= 48'(default_r);
        err_r    <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= result_r;
      out_err_r   <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.channel_value = out_value_r;
  assign out_chan.decode_error  = out_err_r;

endmodule

### tb/tb_rle_anim_channel_decode_core.sv
// Self-checking testbench for the run-length animation channel decoder core.
`timescale 1ns / 100ps

module tb_rle_anim_channel_decode_core;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // one input transfer, at the widths of the channel
  typedef struct {
    rad_pkg::opcode_t   op;
    logic [11:0]        entry_index;
    logic [15:0]        entry_word;
    logic               has_track;
    logic [11:0]        start_index;
    logic [15:0]        frame_number;
    logic signed [31:0] default_value;
    logic signed [31:0] scale_factor;
  } rad_item_t;

  // one decoded channel value as the block should return it
  typedef struct {
    logic signed [47:0] channel_value;
    logic               decode_error;
  } chan_result_t;

  localparam longint SAT_HI      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO      = -SAT_HI - 1;
  localparam int     HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;

  rad_in_if  in_chan ();
  rad_out_if out_chan ();

  rle_anim_channel_decode_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Private copy of the entry store. written_mask marks entries that a load
  // has reached, so that no query is ever built that reads undefined data.
  bit [15:0]    store_mirror [rad_pkg::STORE_DEPTH];
  bit           written_mask [rad_pkg::STORE_DEPTH];
  chan_result_t pending_values [$];

  int error_count;
  int items_sent;
  int sender_idle_pct;
  int receiver_stall_pct;
  bit rx_hold_req;
  int rx_hold_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Walks the span chain as the block does. Returns 0 if the walk would touch
  // an entry never written, in which case the query must not be sent.
  function automatic bit decode_channel(input rad_item_t it, output chan_result_t res);
    int unsigned        pos;
    int unsigned        k;
    int unsigned        valid;
    int unsigned        total;
    int unsigned        vidx;
    bit [15:0]          hdr;
    logic signed [15:0] sample;
    longint             acc;
    res.channel_value = 48'(it.default_value);
    res.decode_error  = 1'b0;
    if (!it.has_track) return 1'b1;
    pos   = 32'(it.start_index);
    k     = 32'(it.frame_number);
    valid = 0;
    while (1) begin
      if (pos >= rad_pkg::STORE_DEPTH) begin
        res.decode_error = 1'b1;
        return 1'b1;
      end
      if (!written_mask[pos]) return 1'b0;
      hdr   = store_mirror[pos];
      valid = 32'(hdr[7:0]);
      total = 32'(hdr[15:8]);
      if (total == 0) begin
        res.decode_error = 1'b1;
        return 1'b1;
      end
      if (total > k) break;
      k   -= total;
      pos += valid + 1;
    end
    // past the valid values the last one is held; with none, the header itself
    vidx = (valid > k) ? pos + k + 1 : pos + valid;
    if (vidx >= rad_pkg::STORE_DEPTH) begin
      res.decode_error = 1'b1;
      return 1'b1;
    end
    if (!written_mask[vidx]) return 1'b0;
    sample = store_mirror[vidx];
    acc    = longint'(sample) * longint'(it.scale_factor) + longint'(it.default_value);
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    res.channel_value = acc[47:0];
    return 1'b1;
  endfunction

  // Q16.16 operand, leaning on the extremes and zero
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // every field random, so that fields the opcode ignores still toggle
  function automatic rad_item_t random_item();
    rad_item_t it;
    it.op            = rad_pkg::opcode_t'($urandom_range(1));
    it.entry_index   = 12'($urandom);
    it.entry_word    = 16'($urandom);
    it.has_track     = 1'($urandom_range(1));
    it.start_index   = 12'($urandom);
    it.frame_number  = 16'($urandom);
    it.default_value = pick_q16();
    it.scale_factor  = pick_q16();
    return it;
  endfunction

  function automatic rad_item_t make_query(input logic track, input logic [11:0] start,
                                           input logic [15:0] frame,
                                           input logic signed [31:0] dflt,
                                           input logic signed [31:0] scl);
    rad_item_t it;
    it               = random_item();
    it.op            = rad_pkg::OP_QUERY;
    it.has_track     = track;
    it.start_index   = start;
    it.frame_number  = frame;
    it.default_value = dflt;
    it.scale_factor  = scl;
    return it;
  endfunction

  // Offers one item and waits for its transfer. valid is left high on return
  // so that back-to-back items keep it high without a glitch.
  task automatic send_item(input rad_item_t it);
    chan_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.opcode        <= it.op;
    in_chan.entry_index   <= it.entry_index;
    in_chan.entry_word    <= it.entry_word;
    in_chan.has_track     <= it.has_track;
    in_chan.start_index   <= it.start_index;
    in_chan.frame_number  <= it.frame_number;
    in_chan.default_value <= it.default_value;
    in_chan.scale_factor  <= it.scale_factor;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (it.op == rad_pkg::OP_LOAD) begin
      store_mirror[it.entry_index] = it.entry_word;
      written_mask[it.entry_index] = 1'b1;
    end else begin
      void'(decode_channel(it, res));
      pending_values.push_back(res);
    end
  endtask

  task automatic send_load(input logic [11:0] idx, input logic [15:0] word);
    rad_item_t it;
    it             = random_item();
    it.op          = rad_pkg::OP_LOAD;
    it.entry_index = idx;
    it.entry_word  = word;
    send_item(it);
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    sender_idle_pct    = (mode == IDLE_SENDER)   ? 52 : (mode == IDLE_BOTH) ? 20 : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? 52 : (mode == IDLE_BOTH) ? 20 : 0;
  endtask

  // Lays down a chain of 1..4 spans at a random base, sometimes close to the
  // top of the store, then queries it a few times.
  task automatic run_track_queries();
    int unsigned  base;
    int unsigned  pos;
    int unsigned  span_sum;
    int unsigned  valid;
    int unsigned  total;
    int unsigned  v;
    int unsigned  pick;
    logic [15:0]  frame;
    rad_item_t    q;
    chan_result_t res;
    base     = ($urandom_range(7) == 0) ? $urandom_range(4095, 4060) : $urandom_range(4095);
    pos      = base;
    span_sum = 0;
    repeat ($urandom_range(4, 1)) begin
      valid = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(6);
      total = ($urandom_range(7) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
      if (pos < rad_pkg::STORE_DEPTH) send_load(pos[11:0], {total[7:0], valid[7:0]});
      for (v = 1; v <= valid; v++)
        if (pos + v < rad_pkg::STORE_DEPTH) send_load(12'(pos + v), 16'($urandom));
      span_sum += total;
      pos      += valid + 1;
    end
    // half the chains end on a zero-total header, so late frames flag an error
    if ($urandom_range(1) == 1 && pos < rad_pkg::STORE_DEPTH)
      send_load(pos[11:0], {8'h00, 8'($urandom)});
    repeat ($urandom_range(5, 2)) begin
      pick = $urandom_range(9);
      if (pick < 6) frame = 16'($urandom_range(span_sum - 1));
      else if (pick < 8) frame = 16'(span_sum + $urandom_range(3));
      else frame = 16'($urandom);
      q = make_query(1'b1, base[11:0], frame, pick_q16(), pick_q16());
      // a frame inside the chain only reads what was just written
      if (!decode_channel(q, res)) q.frame_number = 16'($urandom_range(span_sum - 1));
      send_item(q);
    end
  endtask

  task automatic test_default_only();
    send_item(make_query(1'b0, 12'd0, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(make_query(1'b0, 12'hFFF, 16'h0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
  endtask

  // three spans at entry 0: two values, then none (header read as value),
  // then a zero-total header that stops the walk
  task automatic test_span_walk();
    send_load(12'd0, 16'h0402);
    send_load(12'd1, 16'h7FFF);
    send_load(12'd2, 16'h8000);
    send_load(12'd3, 16'h0300);
    send_load(12'd4, 16'h0000);
    send_item(make_query(1'b1, 12'd0, 16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(make_query(1'b1, 12'd0, 16'd1, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(make_query(1'b1, 12'd0, 16'd3, 32'sh0001_0000, 32'sh0000_8000));
    send_item(make_query(1'b1, 12'd0, 16'd4, 32'sh0000_0000, 32'shFFFF_0000));
    send_item(make_query(1'b1, 12'd0, 16'd7, 32'sh1234_5678, 32'sh0001_0000));
    send_item(make_query(1'b1, 12'd0, 16'hFFFF, 32'shDEAD_BEEF, 32'sh0001_0000));
  endtask

  // spans at the top of the store: header walk and value read past the end
  task automatic test_store_boundary();
    send_load(12'd4094, 16'h0101);
    send_load(12'd4095, 16'h0205);
    send_item(make_query(1'b1, 12'd4094, 16'd0, 32'sh0000_1000, 32'sh0002_0000));
    send_item(make_query(1'b1, 12'd4094, 16'd1, 32'sh0000_1000, 32'sh0002_0000));
    send_item(make_query(1'b1, 12'd4095, 16'd0, 32'sh0000_2000, 32'sh0001_0000));
    send_item(make_query(1'b1, 12'd4095, 16'd4, 32'sh0000_3000, 32'sh0001_0000));
  endtask

  task automatic test_random_traffic(input idle_mode_t mode, input int n_items);
    int           stop_at;
    int unsigned  pick;
    rad_item_t    q;
    chan_result_t res;
    set_idle_mode(mode);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 8) begin
        run_track_queries();
      end else if (pick == 8) begin
        send_load(12'($urandom), 16'($urandom));
      end else begin
        // stray query anywhere; falls back to default-only if it would read
        // entries that hold nothing yet
        q = make_query(1'($urandom_range(1)), 12'($urandom), 16'($urandom),
                       pick_q16(), pick_q16());
        if (!decode_channel(q, res)) q.has_track = 1'b0;
        send_item(q);
      end
    end
  endtask

  // result side held off for a long stretch while items keep coming, so the
  // core fills up and drops in_chan.ready
  task automatic test_output_backpressure(input int n_items);
    int stop_at;
    set_idle_mode(IDLE_NONE);
    rx_hold_req = 1'b1;
    stop_at     = items_sent + n_items;
    while (items_sent < stop_at) run_track_queries();
  endtask

  // result sink: random stalls, plus the long hold-off when requested
  initial begin : result_sink
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // each result transfer against the oldest expected value
  always @(posedge clk) begin : result_check
    chan_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_values.size() == 0) begin
        report_mismatch("result with no query outstanding", out_chan.channel_value, 0);
      end else begin
        want = pending_values.pop_front();
        if (out_chan.channel_value !== want.channel_value)
          report_mismatch("channel_value", out_chan.channel_value, want.channel_value);
        if (out_chan.decode_error !== want.decode_error)
          report_mismatch("decode_error", out_chan.decode_error, want.decode_error);
      end
    end
  end

  initial begin : run_limit
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main_seq
    error_count  = 0;
    items_sent   = 0;
    rx_hold_req  = 1'b0;
    rx_hold_left = 0;
    set_idle_mode(IDLE_NONE);
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.opcode        <= rad_pkg::OP_LOAD;
    in_chan.entry_index   <= '0;
    in_chan.entry_word    <= '0;
    in_chan.has_track     <= 1'b0;
    in_chan.start_index   <= '0;
    in_chan.frame_number  <= '0;
    in_chan.default_value <= '0;
    in_chan.scale_factor  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_only();
    test_span_walk();
    test_store_boundary();
    test_random_traffic(IDLE_NONE, 200);
    test_random_traffic(IDLE_SENDER, 200);
    test_random_traffic(IDLE_RECEIVER, 200);
    test_random_traffic(IDLE_BOTH, 200);
    test_output_backpressure(130);

    in_chan.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    // let any late or spurious result show itself
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
